@@ hw/rtl/brti_pkg.sv @@
// Package for the bitmap row to intervals block.
// Holds the shared widths, lane and slot types, and the packet type.
// No dependencies.
package brti_pkg;

	localparam int LANES     = 8;
	localparam int SLOTS     = LANES + 1;
	localparam int SLOT_IW   = $clog2(SLOTS);
	localparam int COL_W     = 12;
	localparam int LINE_W    = 16;
	localparam int CFG_W     = 13;
	localparam int FLUSH_IDX = LANES;

	localparam logic [CFG_W-1:0] ROW_WIDTH_RESET = 13'd4096;

	typedef struct packed {
		logic run_out;
		logic open;
		logic close;
	} lane_t;

	typedef struct packed {
		logic [COL_W-1:0] left;
		logic [COL_W-1:0] right;
	} slot_t;

	typedef struct packed {
		logic [SLOTS-1:0]        mask;
		logic signed [LINE_W-1:0] line;
		slot_t [SLOTS-1:0]       slot;
	} pkt_t;

endpackage

@@ hw/rtl/brti_lane.sv @@
// One pixel lane: checks the pixel against the row width and finds run edges.
// Depends on brti_pkg.
module brti_lane #(
	parameter int AW = 14
) (
	input  logic [AW-1:0]   col,
	input  logic [AW-1:0]   width,
	input  logic            pixel,
	input  logic            prev_run,
	output brti_pkg::lane_t lane
);

	logic in_row;

	assign in_row        = col < width;
	assign lane.run_out  = in_row ? pixel : prev_run;
	assign lane.open     = in_row & pixel & ~prev_run;
	assign lane.close    = in_row & ~pixel & prev_run;

endmodule

@@ hw/rtl/brti_front.sv @@
// Front stage: row state, the eight pixel lanes and the merge of their run edges
// into one packet of intervals. Depends on brti_pkg and brti_lane.
module brti_front #(
	parameter int MAX_ROW_WIDTH = 4096
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [brti_pkg::CFG_W-1:0]          row_width,
	input  logic [7:0]                          mask_byte,
	input  logic signed [brti_pkg::LINE_W-1:0]  line_coord,
	input  logic                                accept,
	output brti_pkg::pkt_t                      pkt
);

	localparam int PW = $clog2(MAX_ROW_WIDTH + 1);
	localparam int AW = ((PW > brti_pkg::CFG_W) ? PW : brti_pkg::CFG_W) + 1;

	logic [PW-1:0] pos_q;
	logic          in_run_q;
	logic [PW-1:0] start_q;

	logic [AW-1:0] width_raw;
	logic [AW-1:0] width_eff;
	logic [AW-1:0] pos;
	logic [AW-1:0] pos_end;
	logic [AW-1:0] valid_end;
	logic [AW-1:0] last;
	logic          row_end;

	logic [AW-1:0]        col   [brti_pkg::LANES];
	brti_pkg::lane_t      lanes [brti_pkg::LANES];
	logic [brti_pkg::LANES:0] run_chain;
	logic [AW-1:0]        start_chain [brti_pkg::LANES+1];

	assign width_raw = AW'(row_width);
	always_comb begin
		width_eff = width_raw;
		if (width_raw == '0) begin
			width_eff = AW'(1);
		end else if (width_raw > AW'(MAX_ROW_WIDTH)) begin
			width_eff = AW'(MAX_ROW_WIDTH);
		end
	end

	assign pos     = AW'(pos_q);
	assign pos_end = pos + AW'(brti_pkg::LANES);
	assign row_end = pos_end >= width_eff;

	assign run_chain[0]   = in_run_q;
	assign start_chain[0] = AW'(start_q);

	for (genvar i = 0; i < brti_pkg::LANES; i++) begin : g_lane
		assign col[i] = pos + AW'(i);

		brti_lane #(
			.AW (AW)
		) u_lane (
			.col      (col[i]),
			.width    (width_eff),
			.pixel    (mask_byte[i]),
			.prev_run (run_chain[i]),
			.lane     (lanes[i])
		);

		assign run_chain[i+1]   = lanes[i].run_out;
		assign start_chain[i+1] = lanes[i].open ? col[i] : start_chain[i];
	end

	assign valid_end = (pos_end < width_eff) ? pos_end : width_eff;
	assign last      = (valid_end > pos) ? valid_end : pos;

	always_comb begin
		logic [AW-1:0] right;
		pkt.line = line_coord;
		for (int i = 0; i < brti_pkg::LANES; i++) begin
			right                = col[i] - AW'(1);
			pkt.mask[i]          = lanes[i].close;
			pkt.slot[i].left     = start_chain[i][brti_pkg::COL_W-1:0];
			pkt.slot[i].right    = right[brti_pkg::COL_W-1:0];
		end
		right = last - AW'(1);
		pkt.mask[brti_pkg::FLUSH_IDX]       = row_end & run_chain[brti_pkg::LANES];
		pkt.slot[brti_pkg::FLUSH_IDX].left  =
			start_chain[brti_pkg::LANES][brti_pkg::COL_W-1:0];
		pkt.slot[brti_pkg::FLUSH_IDX].right = right[brti_pkg::COL_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			in_run_q <= 1'b0;
			start_q  <= '0;
		end else if (accept) begin
			start_q <= start_chain[brti_pkg::LANES][PW-1:0];
			if (row_end) begin
				pos_q    <= '0;
				in_run_q <= 1'b0;
			end else begin
				pos_q    <= pos_end[PW-1:0];
				in_run_q <= run_chain[brti_pkg::LANES];
			end
		end
	end

endmodule

@@ hw/rtl/brti_drain.sv @@
// Drain stage: holds one packet of intervals and hands them out one per item,
// in column order, through an output register. Depends on brti_pkg.
module brti_drain (
	input  logic                               clk,
	input  logic                               arst_n,
	input  brti_pkg::pkt_t                     pkt,
	input  logic                               in_valid,
	output logic                               in_stall,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [brti_pkg::LINE_W-1:0] out_line,
	output logic [brti_pkg::COL_W-1:0]         run_left,
	output logic [brti_pkg::COL_W-1:0]         run_right,
	output logic                               last_of_item
);

	logic [brti_pkg::SLOTS-1:0]        mask_q;
	logic signed [brti_pkg::LINE_W-1:0] line_q;
	brti_pkg::slot_t [brti_pkg::SLOTS-1:0] slot_q;

	logic                               out_valid_q;
	logic signed [brti_pkg::LINE_W-1:0] out_line_q;
	logic [brti_pkg::COL_W-1:0]         run_left_q;
	logic [brti_pkg::COL_W-1:0]         run_right_q;
	logic                               last_q;

	logic [brti_pkg::SLOT_IW-1:0] sel;
	logic [brti_pkg::SLOTS-1:0]   rest;
	logic                         pop;
	logic                         accept;

	always_comb begin
		sel = '0;
		for (int k = brti_pkg::SLOTS - 1; k >= 0; k--) begin
			if (mask_q[k]) begin
				sel = brti_pkg::SLOT_IW'(k);
			end
		end
	end

	assign rest     = mask_q & ~(brti_pkg::SLOTS'(1) << sel);
	assign pop      = (|mask_q) & (~out_valid_q | ~out_stall);
	assign in_stall = ~((mask_q == '0) | ((rest == '0) & pop));
	assign accept   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (accept) begin
			mask_q <= pkt.mask;
		end else if (pop) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			line_q <= pkt.line;
			slot_q <= pkt.slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_line_q  <= line_q;
			run_left_q  <= slot_q[sel].left;
			run_right_q <= slot_q[sel].right;
			last_q      <= (rest == '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign out_line     = out_line_q;
	assign run_left     = run_left_q;
	assign run_right    = run_right_q;
	assign last_of_item = last_q;

endmodule

@@ hw/rtl/bitmap_row_to_intervals_top.sv @@
// Top level of the bitmap row to intervals block.
// Holds the row width register and joins the front and drain stages.
// Depends on brti_pkg, brti_front and brti_drain.
//
// Usage:
// The input channel takes one mask byte per item (bit 0 is the leftmost pixel)
// with the line coordinate of its row; in_valid and in_stall shake hands.
// The output channel gives one interval per item: line, left and right column
// (inclusive), and last_of_item on the final interval caused by an input byte.
// Each byte yields zero to five intervals. A byte that yields at most one is
// taken every cycle while the output does not stall; a byte that yields more
// holds the input until its last interval goes to the single output register,
// which hands out one interval per cycle unless stalled. The row width register
// is written over row_width_valid / row_width_ready; the user must write it only
// while the block is idle, which the block does not enforce; it is always ready.
// A width of zero acts as one. Reset clears the column position and any open run
// and sets the width to 4096. A stall on the output holds the interval in place;
// the input then stalls while the drain still holds intervals of an earlier byte.
module bitmap_row_to_intervals_top #(
	parameter int MAX_ROW_WIDTH = 4096
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               row_width_valid,
	output logic                               row_width_ready,
	input  logic [brti_pkg::CFG_W-1:0]         row_width,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [7:0]                         mask_byte,
	input  logic signed [brti_pkg::LINE_W-1:0] line_coord,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic signed [brti_pkg::LINE_W-1:0] out_line,
	output logic [brti_pkg::COL_W-1:0]         run_left,
	output logic [brti_pkg::COL_W-1:0]         run_right,
	output logic                               last_of_item
);

	logic [brti_pkg::CFG_W-1:0] row_width_q;
	brti_pkg::pkt_t             pkt;
	logic                       accept;

	assign row_width_ready = 1'b1;
	assign accept          = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= brti_pkg::ROW_WIDTH_RESET;
		end else if (row_width_valid && row_width_ready) begin
			row_width_q <= row_width;
		end
	end

	brti_front #(
		.MAX_ROW_WIDTH (MAX_ROW_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.row_width  (row_width_q),
		.mask_byte  (mask_byte),
		.line_coord (line_coord),
		.accept     (accept),
		.pkt        (pkt)
	);

	brti_drain u_drain (
		.clk          (clk),
		.arst_n       (arst_n),
		.pkt          (pkt),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_line     (out_line),
		.run_left     (run_left),
		.run_right    (run_right),
		.last_of_item (last_of_item)
	);

endmodule

@@ hw/rtl/brti_checker.sv @@
// Port-level checks for the bitmap row to intervals block, bound to its top level.
// Depends on brti_pkg and bitmap_row_to_intervals_top.
module brti_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_stall,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic signed [brti_pkg::LINE_W-1:0] out_line,
	input logic [brti_pkg::COL_W-1:0]         run_left,
	input logic [brti_pkg::COL_W-1:0]         run_right,
	input logic                               last_of_item
);

	// A stalled interval holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_line) && $stable(run_left)
			&& $stable(run_right) && $stable(last_of_item))
		else $error("stalled output item changed");

	// No interval is shown while reset is applied.
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !out_valid)
		else $error("output valid during reset");

	// The intervals of one byte leave back to back when the receiver keeps up.
	a_burst: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_of_item |=> out_valid)
		else $error("gap inside an interval burst");

	// A stalled input with an empty output register means intervals are pending.
	a_pending: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && !out_valid |=> out_valid)
		else $error("input stalled with no interval delivered");

endmodule

bind bitmap_row_to_intervals_top brti_checker u_brti_checker (.*);
